@@ rtl/wwve_pkg.sv @@
package wwve_pkg;

	localparam int POS_W                = 32;
	localparam int STAMP_W              = 32;
	localparam int TPS_W                = 24;
	localparam int DIFF_W               = POS_W + 1;
	localparam int PROD_W               = DIFF_W + TPS_W;
	localparam int WINDOW_DEPTH_DEFAULT = 5;

	localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000000);

	// Sample transaction: both wheel positions and the timestamp
	typedef struct packed {
		logic signed [POS_W-1:0] left_position;
		logic signed [POS_W-1:0] right_position;
		logic [STAMP_W-1:0]      stamp;
	} sample_t;

	// Result transaction: both wheel velocities and the zero interval flag
	typedef struct packed {
		logic signed [POS_W-1:0] left_velocity;
		logic signed [POS_W-1:0] right_velocity;
		logic                    zero_interval;
	} result_t;

endpackage

@@ rtl/windowed_wheel_velocity_estimator_unit.sv @@
// Sliding-window wheel velocity estimator.
// Sample channel (sample_valid / sample_stall / sample): one transaction per
// timestamped pair of Q16.16 wheel positions. Result channel (result_valid /
// result_stall / result): one transaction of Q16.16-per-second velocities.
// The block stores the last WINDOW_DEPTH-1 samples. The first WINDOW_DEPTH
// samples only fill the window and give no result; every later sample gives
// (newest - oldest kept position) * ticks_per_second / dt, truncated toward
// zero and saturated to 32 bits. A zero dt gives zero velocities and sets
// zero_interval. ticks_per_second is written through cfg_write_enable /
// cfg_write_data by the user only while the block is idle; it is not enforced.
// Timing: one shared 33x24 multiplier and one restoring divider retiring one
// quotient bit a cycle serve both wheels. Per wheel: a multiply step, the
// divide steps and a saturate step. A result is loaded into the output
// register in the finish state (reached directly for a zero dt), and the
// next sample is taken the cycle after; warm-up samples leave the block idle.
// sample_stall is high while a sample is being worked on. A result held by
// result_stall waits in the output register; the next sample is still taken,
// and its result waits until the register is free.
// Reset clears the window fill count, the output valid and restores
// ticks_per_second to 1000000.
module windowed_wheel_velocity_estimator_unit #(
	parameter int WINDOW_DEPTH = wwve_pkg::WINDOW_DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write_enable,
	input  logic [wwve_pkg::TPS_W-1:0]  cfg_write_data,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  wwve_pkg::sample_t           sample,
	output logic                        result_valid,
	input  logic                        result_stall,
	output wwve_pkg::result_t           result
);
	import wwve_pkg::*;

	localparam int HIST_LEN = WINDOW_DEPTH - 1;
	localparam int PTR_W    = (HIST_LEN > 1) ? $clog2(HIST_LEN) : 1;
	localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
	localparam int STEP_W   = $clog2(PROD_W);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_SAT,
		ST_FINISH
	} state_t;

	state_t             state_q;
	logic [TPS_W-1:0]   tps_q;
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [FILL_W-1:0]  fill_q;
	logic [STEP_W-1:0]  step_q;
	logic               wheel_q;
	logic               result_valid_q;
	result_t            result_q;

	logic [POS_W-1:0]   hist_left_q  [HIST_LEN];
	logic [POS_W-1:0]   hist_right_q [HIST_LEN];
	logic [STAMP_W-1:0] hist_stamp_q [HIST_LEN];

	logic signed [DIFF_W-1:0] diff_left_q;
	logic signed [DIFF_W-1:0] diff_right_q;
	logic [STAMP_W-1:0]       dt_q;
	logic                     zero_q;
	logic                     neg_q;
	logic [PROD_W-1:0]        quo_q;
	logic [STAMP_W-1:0]       rem_q;
	logic [POS_W-1:0]         vel_left_q;
	logic [POS_W-1:0]         vel_right_q;

	logic                     sample_fire;
	logic                     result_fire;
	logic                     load_result;
	logic                     window_full;
	logic [STAMP_W-1:0]       dt_w;
	logic signed [DIFF_W-1:0] diff_left_w;
	logic signed [DIFF_W-1:0] diff_right_w;
	logic signed [DIFF_W-1:0] cur_diff;
	logic                     cur_neg;
	logic [DIFF_W-1:0]        cur_mag;
	logic [PROD_W-1:0]        prod_w;
	logic [STAMP_W:0]         trial;
	logic [STAMP_W:0]         trial_sub;
	logic                     trial_ge;
	logic                     over;
	logic [POS_W-1:0]         sat_w;
	logic [PTR_W-1:0]         ptr_next;

	// Handshakes
	assign sample_stall = (state_q != ST_IDLE);
	assign sample_fire  = sample_valid && !sample_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign result_fire  = result_valid_q && !result_stall;
	assign load_result  = (state_q == ST_FINISH) && (!result_valid_q || result_fire);
	assign window_full  = (fill_q == FILL_W'(WINDOW_DEPTH));

	// Differences against the oldest kept sample
	assign dt_w         = sample.stamp - hist_stamp_q[wr_ptr_q];
	assign diff_left_w  = DIFF_W'(sample.left_position)
	                    - DIFF_W'($signed(hist_left_q[wr_ptr_q]));
	assign diff_right_w = DIFF_W'(sample.right_position)
	                    - DIFF_W'($signed(hist_right_q[wr_ptr_q]));
	assign ptr_next     = (wr_ptr_q == PTR_W'(HIST_LEN - 1)) ? '0 : wr_ptr_q + 1'b1;

	// Shared multiplier: magnitude of the selected difference times tick rate
	assign cur_diff = wheel_q ? diff_right_q : diff_left_q;
	assign cur_neg  = cur_diff[DIFF_W-1];
	assign cur_mag  = cur_neg ? DIFF_W'(-cur_diff) : DIFF_W'(cur_diff);
	assign prod_w   = PROD_W'(cur_mag) * PROD_W'(tps_q);

	// Shared divider: one restoring step a cycle
	assign trial     = {rem_q, quo_q[PROD_W-1]};
	assign trial_sub = trial - {1'b0, dt_q};
	assign trial_ge  = (trial >= {1'b0, dt_q});

	// Saturate the unsigned quotient to a signed 32-bit result
	always_comb begin
		if (neg_q) begin
			over  = (|quo_q[PROD_W-1:POS_W]) || (quo_q[POS_W-1] && (|quo_q[POS_W-2:0]));
			sat_w = over ? {1'b1, {(POS_W-1){1'b0}}} : POS_W'(-quo_q[POS_W-1:0]);
		end else begin
			over  = |quo_q[PROD_W-1:POS_W-1];
			sat_w = over ? {1'b0, {(POS_W-1){1'b1}}} : quo_q[POS_W-1:0];
		end
	end

	// Sequencer, configuration register and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			tps_q          <= TPS_RESET;
			wr_ptr_q       <= '0;
			fill_q         <= '0;
			step_q         <= '0;
			wheel_q        <= 1'b0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if (cfg_write_enable) begin
				tps_q <= cfg_write_data;
			end
			if (load_result) begin
				result_valid_q <= 1'b1;
			end else if (result_fire) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (sample_fire) begin
						wr_ptr_q <= ptr_next;
						if (!window_full) begin
							fill_q <= fill_q + 1'b1;
						end else if (dt_w == '0) begin
							state_q <= ST_FINISH;
						end else begin
							wheel_q <= 1'b0;
							state_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					step_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(PROD_W - 1)) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					if (!wheel_q) begin
						wheel_q <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					// Hold until the output register is free
					if (load_result) begin
						result_q.left_velocity  <= vel_left_q;
						result_q.right_velocity <= vel_right_q;
						result_q.zero_interval  <= zero_q;
						state_q                 <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Window history and arithmetic datapath
	always_ff @(posedge clk) begin
		if (sample_fire) begin
			hist_left_q[wr_ptr_q]  <= sample.left_position;
			hist_right_q[wr_ptr_q] <= sample.right_position;
			hist_stamp_q[wr_ptr_q] <= sample.stamp;
			diff_left_q            <= diff_left_w;
			diff_right_q           <= diff_right_w;
			dt_q                   <= dt_w;
			zero_q                 <= (dt_w == '0);
			if (dt_w == '0) begin
				vel_left_q  <= '0;
				vel_right_q <= '0;
			end
		end
		case (state_q)
			ST_MUL: begin
				quo_q <= prod_w;
				rem_q <= '0;
				neg_q <= cur_neg;
			end
			ST_DIV: begin
				quo_q <= {quo_q[PROD_W-2:0], trial_ge};
				rem_q <= trial_ge ? trial_sub[STAMP_W-1:0] : trial[STAMP_W-1:0];
			end
			ST_SAT: begin
				if (!wheel_q) begin
					vel_left_q <= sat_w;
				end else begin
					vel_right_q <= sat_w;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
